@@ design/e2r_pkg.sv @@
`default_nettype none
package e2r_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int TAG_BITS   = 16;
  localparam int OUT_BITS   = FRAC_BITS + 2;

  // Taylor terms per series and pipeline depths of the three sections.
  localparam int TERMS    = 8;
  localparam int SC_DEPTH = 4 + 3 * TERMS;
  localparam int QT_DEPTH = 4;
  localparam int MX_DEPTH = 4;

  localparam int NUM_LANES = 3;
  localparam int LANE_X    = 0;
  localparam int LANE_Y    = 1;
  localparam int LANE_Z    = 2;

  localparam logic [31:0] PI_Q30   = 32'hC90F_DAA2;
  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
  localparam logic [31:0] HALF_Q30 = 32'h2000_0000;

  localparam int          OUT_SHIFT = 30 - FRAC_BITS;
  localparam logic [35:0] OUT_HALF  = (OUT_SHIFT == 0) ? 36'd0 :
                                      36'(64'd1 << (OUT_SHIFT - 1));
  localparam logic [35:0] OUT_LIM   = 36'(64'd1 << (FRAC_BITS + 1));

  typedef logic [TAG_BITS-1:0]          tag_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [OUT_BITS-1:0]   entry_t;
  typedef logic signed [32:0]           q30_t;

  typedef struct packed {
    logic        neg;
    logic [65:0] mag;
  } rawp_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
  } item_ctl_t;

  function automatic int cos_div(input int i);
    return (2 * i + 1) * (2 * i + 2);
  endfunction

  function automatic int sin_div(input int i);
    return (2 * i + 2) * (2 * i + 3);
  endfunction

  // Sign and magnitude product of two Q30 values, rounded in the next stage.
  function automatic rawp_t raw_mul(input q30_t a, input q30_t b);
    logic [32:0] ma;
    logic [32:0] mb;
    rawp_t       r;
    ma    = a[32] ? 33'(-a) : 33'(a);
    mb    = b[32] ? 33'(-b) : 33'(b);
    r.neg = a[32] ^ b[32];
    r.mag = 66'(ma) * 66'(mb);
    return r;
  endfunction

  // Round to Q30, half away from zero.
  function automatic q30_t round_q30(input rawp_t p);
    logic [66:0] s;
    logic [32:0] m;
    s = 67'(p.mag) + 67'(HALF_Q30);
    m = 33'(s >> 30);
    return p.neg ? $signed(-m) : $signed(m);
  endfunction

  // Round a Q30 entry to the output format and saturate.
  function automatic entry_t to_out(input logic signed [35:0] v);
    logic [35:0] mg;
    logic [35:0] m;
    mg = v[35] ? 36'(-v) : 36'(v);
    m  = (mg + OUT_HALF) >> OUT_SHIFT;
    if (v[35]) begin
      if (m > OUT_LIM) m = OUT_LIM;
      return $signed(OUT_BITS'(-m));
    end
    if (m > OUT_LIM - 36'd1) m = OUT_LIM - 36'd1;
    return $signed(OUT_BITS'(m));
  endfunction

endpackage
`default_nettype wire

@@ design/e2r_in_if.sv @@
`default_nettype none
interface e2r_in_if;
  logic              valid;
  logic              ready;
  e2r_pkg::tag_t     part_index;
  e2r_pkg::angle_t   angle_x;
  e2r_pkg::angle_t   angle_y;
  e2r_pkg::angle_t   angle_z;

  modport source (output valid, part_index, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, part_index, angle_x, angle_y, angle_z, output ready);
endinterface
`default_nettype wire

@@ design/e2r_out_if.sv @@
`default_nettype none
interface e2r_out_if;
  logic            valid;
  logic            ready;
  e2r_pkg::tag_t   part_tag;
  e2r_pkg::entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, part_tag, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, part_tag, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface
`default_nettype wire

@@ design/e2r_sincos.sv @@
`default_nettype none
module e2r_sincos (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  e2r_pkg::item_ctl_t  ctl_in,
  input  e2r_pkg::angle_t     angle [3],
  output e2r_pkg::item_ctl_t  ctl_out,
  output e2r_pkg::q30_t       sin_q [3],
  output e2r_pkg::q30_t       cos_q [3]
);
  import e2r_pkg::*;

  localparam int PW = ANGLE_BITS + 32;
  localparam logic [PW-1:0] PHI_HALF = PW'(1) << (ANGLE_BITS - 1);

  typedef struct packed {
    logic               neg;
    logic [31:0]        x2;
    logic [31:0]        tc;
    logic [31:0]        ts;
    logic signed [33:0] sumc;
    logic signed [33:0] sums;
  } term_t;

  item_ctl_t ctl [SC_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SC_DEPTH; k++) ctl[k].valid <= 1'b0;
    end else if (en) begin
      ctl[0] <= ctl_in;
      for (int k = 1; k < SC_DEPTH; k++) ctl[k] <= ctl[k-1];
    end
  end

  assign ctl_out = ctl[SC_DEPTH-1];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic [ANGLE_BITS-1:0] raw;
    logic [ANGLE_BITS-1:0] mag;
    logic [PW-1:0]         prod1;
    logic [31:0]           phi2;
    logic [31:0]           phi3;
    logic [63:0]           pp;
    logic                  neg1, neg2, neg3;
    term_t                 chain [TERMS+1];

    assign raw = angle[l];
    assign mag = raw[ANGLE_BITS-1] ? -raw : raw;

    // Half angle in radians, then its square, both Q30.
    always_ff @(posedge clk) begin
      if (en) begin
        prod1         <= PW'(mag) * PW'(PI_Q30);
        neg1          <= raw[ANGLE_BITS-1];
        phi2          <= 32'((prod1 + PHI_HALF) >> ANGLE_BITS);
        neg2          <= neg1;
        pp            <= 64'(phi2) * 64'(phi2);
        phi3          <= phi2;
        neg3          <= neg2;
        chain[0].x2   <= 32'((65'(pp) + 65'(HALF_Q30)) >> 30);
        chain[0].tc   <= ONE_Q30;
        chain[0].ts   <= phi3;
        chain[0].sumc <= $signed(34'(ONE_Q30));
        chain[0].sums <= $signed({2'b00, phi3});
        chain[0].neg  <= neg3;
      end
    end

    // One Taylor term per series per step, cosine only in the last: multiply,
    // scale, estimate the quotient by a reciprocal, correct it and accumulate.
    for (genvar i = 0; i < TERMS; i++) begin : g_step
      localparam int          DC     = cos_div(i);
      localparam int          DS     = sin_div(i);
      localparam logic [32:0] DCW    = 33'(DC);
      localparam logic [32:0] DSW    = 33'(DS);
      localparam logic [32:0] RC     = 33'((64'd1 << 33) / DC);
      localparam logic [32:0] RS     = 33'((64'd1 << 33) / DS);
      localparam bit          SUB    = (i % 2 == 0);
      localparam bit          S_LIVE = (i < TERMS - 1);

      term_t       sa, sb;
      logic [63:0] pc, ps;
      logic [32:0] qc, qs, qc_n, qs_n, estc, ests, remc, rems;
      logic [65:0] ec, es;
      logic [31:0] tc_n, ts_n;

      assign qc_n = 33'((65'(pc) + 65'(HALF_Q30)) >> 30);
      assign qs_n = 33'((65'(ps) + 65'(HALF_Q30)) >> 30);
      assign estc = ec[65:33];
      assign ests = es[65:33];
      assign remc = qc - estc * DCW;
      assign rems = qs - ests * DSW;
      assign tc_n = 32'((remc >= DCW) ? estc + 33'd1 : estc);
      assign ts_n = 32'((rems >= DSW) ? ests + 33'd1 : ests);

      always_ff @(posedge clk) begin
        if (en) begin
          sa <= chain[i];
          pc <= 64'(chain[i].tc) * 64'(chain[i].x2);
          ps <= 64'(chain[i].ts) * 64'(chain[i].x2);
          sb <= sa;
          qc <= qc_n;
          qs <= qs_n;
          ec <= 66'(qc_n) * 66'(RC);
          es <= 66'(qs_n) * 66'(RS);
          chain[i+1].neg  <= sb.neg;
          chain[i+1].x2   <= sb.x2;
          chain[i+1].tc   <= tc_n;
          chain[i+1].sumc <= SUB ? sb.sumc - $signed({2'b00, tc_n})
                                 : sb.sumc + $signed({2'b00, tc_n});
          if (S_LIVE) begin
            chain[i+1].ts   <= ts_n;
            chain[i+1].sums <= SUB ? sb.sums - $signed({2'b00, ts_n})
                                   : sb.sums + $signed({2'b00, ts_n});
          end else begin
            chain[i+1].ts   <= sb.ts;
            chain[i+1].sums <= sb.sums;
          end
        end
      end
    end

    assign sin_q[l] = chain[TERMS].neg ? 33'(-chain[TERMS].sums) : 33'(chain[TERMS].sums);
    assign cos_q[l] = 33'(chain[TERMS].sumc);
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_chk
    a_cos_range: assert property (@(posedge clk) disable iff (rst)
      ctl_out.valid |-> (cos_q[l] <= $signed(33'(ONE_Q30) + 33'd64) &&
                         cos_q[l] >= -33'sd64))
      else $error("half-angle cosine out of range");
    a_sin_range: assert property (@(posedge clk) disable iff (rst)
      ctl_out.valid |-> (sin_q[l] <= $signed(33'(ONE_Q30) + 33'd64) &&
                         sin_q[l] >= -$signed(33'(ONE_Q30) + 33'd64)))
      else $error("half-angle sine out of range");
  end

endmodule
`default_nettype wire

@@ design/e2r_quat.sv @@
`default_nettype none
module e2r_quat (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  e2r_pkg::item_ctl_t  ctl_in,
  input  e2r_pkg::q30_t       sin_q [3],
  input  e2r_pkg::q30_t       cos_q [3],
  output e2r_pkg::item_ctl_t  ctl_out,
  output e2r_pkg::q30_t       quat_w,
  output e2r_pkg::q30_t       quat_x,
  output e2r_pkg::q30_t       quat_y,
  output e2r_pkg::q30_t       quat_z
);
  import e2r_pkg::*;

  item_ctl_t ctl [QT_DEPTH];
  rawp_t     p_czcy, p_szsy, p_czsy, p_szcy;
  q30_t      cx1, sx1, cx2, sx2, czcy, szsy, czsy, szcy;
  rawp_t     p_w0, p_w1, p_x0, p_x1, p_y0, p_y1, p_z0, p_z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QT_DEPTH; k++) ctl[k].valid <= 1'b0;
    end else if (en) begin
      ctl[0] <= ctl_in;
      for (int k = 1; k < QT_DEPTH; k++) ctl[k] <= ctl[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_czcy <= raw_mul(cos_q[LANE_Z], cos_q[LANE_Y]);
      p_szsy <= raw_mul(sin_q[LANE_Z], sin_q[LANE_Y]);
      p_czsy <= raw_mul(cos_q[LANE_Z], sin_q[LANE_Y]);
      p_szcy <= raw_mul(sin_q[LANE_Z], cos_q[LANE_Y]);
      cx1    <= cos_q[LANE_X];
      sx1    <= sin_q[LANE_X];

      czcy <= round_q30(p_czcy);
      szsy <= round_q30(p_szsy);
      czsy <= round_q30(p_czsy);
      szcy <= round_q30(p_szcy);
      cx2  <= cx1;
      sx2  <= sx1;

      p_w0 <= raw_mul(czcy, cx2);
      p_w1 <= raw_mul(szsy, sx2);
      p_x0 <= raw_mul(czcy, sx2);
      p_x1 <= raw_mul(szsy, cx2);
      p_y0 <= raw_mul(czsy, cx2);
      p_y1 <= raw_mul(szcy, sx2);
      p_z0 <= raw_mul(szcy, cx2);
      p_z1 <= raw_mul(czsy, sx2);

      quat_w <= round_q30(p_w0) + round_q30(p_w1);
      quat_x <= round_q30(p_x0) - round_q30(p_x1);
      quat_y <= round_q30(p_y0) + round_q30(p_y1);
      quat_z <= round_q30(p_z0) - round_q30(p_z1);
    end
  end

  assign ctl_out = ctl[QT_DEPTH-1];

endmodule
`default_nettype wire

@@ design/e2r_mat.sv @@
`default_nettype none
module e2r_mat (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  e2r_pkg::item_ctl_t  ctl_in,
  input  e2r_pkg::q30_t       quat_w,
  input  e2r_pkg::q30_t       quat_x,
  input  e2r_pkg::q30_t       quat_y,
  input  e2r_pkg::q30_t       quat_z,
  output e2r_pkg::item_ctl_t  ctl_out,
  output e2r_pkg::entry_t     m [9]
);
  import e2r_pkg::*;

  item_ctl_t          ctl [MX_DEPTH];
  rawp_t              p_ww, p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  q30_t               ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [35:0] s [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MX_DEPTH; k++) ctl[k].valid <= 1'b0;
    end else if (en) begin
      ctl[0] <= ctl_in;
      for (int k = 1; k < MX_DEPTH; k++) ctl[k] <= ctl[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ww <= raw_mul(quat_w, quat_w);
      p_xx <= raw_mul(quat_x, quat_x);
      p_yy <= raw_mul(quat_y, quat_y);
      p_zz <= raw_mul(quat_z, quat_z);
      p_xy <= raw_mul(quat_x, quat_y);
      p_xz <= raw_mul(quat_x, quat_z);
      p_yz <= raw_mul(quat_y, quat_z);
      p_wx <= raw_mul(quat_w, quat_x);
      p_wy <= raw_mul(quat_w, quat_y);
      p_wz <= raw_mul(quat_w, quat_z);

      ww <= round_q30(p_ww);
      xx <= round_q30(p_xx);
      yy <= round_q30(p_yy);
      zz <= round_q30(p_zz);
      xy <= round_q30(p_xy);
      xz <= round_q30(p_xz);
      yz <= round_q30(p_yz);
      wx <= round_q30(p_wx);
      wy <= round_q30(p_wy);
      wz <= round_q30(p_wz);

      s[0] <= 36'(ww) + 36'(xx) - 36'(yy) - 36'(zz);
      s[1] <= (36'(xy) - 36'(wz)) <<< 1;
      s[2] <= (36'(xz) + 36'(wy)) <<< 1;
      s[3] <= (36'(xy) + 36'(wz)) <<< 1;
      s[4] <= 36'(ww) - 36'(xx) + 36'(yy) - 36'(zz);
      s[5] <= (36'(yz) - 36'(wx)) <<< 1;
      s[6] <= (36'(xz) - 36'(wy)) <<< 1;
      s[7] <= (36'(yz) + 36'(wx)) <<< 1;
      s[8] <= 36'(ww) - 36'(xx) - 36'(yy) + 36'(zz);

      for (int k = 0; k < 9; k++) m[k] <= to_out(s[k]);
    end
  end

  assign ctl_out = ctl[MX_DEPTH-1];

endmodule
`default_nettype wire

@@ design/euler_to_rotation_matrix_unit.sv @@
`default_nettype none
// Euler angle (ZYX) to rotation matrix unit.
// The angles channel carries one transaction per part: a 16-bit tag and three
// signed binary angles about x, y and z, where the full signed range spans
// minus pi to pi. The matrix channel returns one transaction per input with
// the tag echoed and the nine rotation entries in signed Q2.16, saturated.
// Both channels use a valid/ready handshake; a transaction moves on a clock
// edge where valid and ready are both high.
// The pipeline has 36 register stages: a transaction accepted at one edge moves
// through them in order and is offered from the last, the output register. The
// sine and cosine series (eight Taylor terms of three stages each, after four
// half-angle stages) set most of that depth; the quaternion and matrix
// products add eight more stages.
// Throughput is one transaction per cycle: a new angle set can be accepted
// on every clock while the output side keeps taking results.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and ready on the angles channel drops; nothing is dropped or repeated.
// A synchronous reset clears all valid bits, so no result is offered until
// a new transaction has passed through. No other state is reset.
module euler_to_rotation_matrix_unit (
  input  logic       clk,
  input  logic       rst,
  e2r_in_if.sink     angles,
  e2r_out_if.source  matrix
);
  import e2r_pkg::*;

  localparam entry_t DIAG_MAX = $signed(OUT_BITS'((64'd1 << FRAC_BITS) + 64'd64));

  logic      en;
  item_ctl_t ctl_sc_in, ctl_sc, ctl_qt, ctl_mx;
  angle_t    ang [3];
  q30_t      sin_q [3];
  q30_t      cos_q [3];
  q30_t      quat_w, quat_x, quat_y, quat_z;
  entry_t    m [9];

  // The pipeline advances whenever the output register is empty or being read.
  assign en           = !matrix.valid || matrix.ready;
  assign angles.ready = en;

  assign ctl_sc_in.valid = angles.valid;
  assign ctl_sc_in.tag   = angles.part_index;
  assign ang[LANE_X]     = angles.angle_x;
  assign ang[LANE_Y]     = angles.angle_y;
  assign ang[LANE_Z]     = angles.angle_z;

  // Half-angle sine and cosine for all three axes.
  e2r_sincos u_sincos (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_sc_in),
    .angle   (ang),
    .ctl_out (ctl_sc),
    .sin_q   (sin_q),
    .cos_q   (cos_q)
  );

  // ZYX unit quaternion.
  e2r_quat u_quat (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_sc),
    .sin_q   (sin_q),
    .cos_q   (cos_q),
    .ctl_out (ctl_qt),
    .quat_w  (quat_w),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z)
  );

  // Rotation matrix; its last stage is the output register.
  e2r_mat u_mat (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_qt),
    .quat_w  (quat_w),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z),
    .ctl_out (ctl_mx),
    .m       (m)
  );

  assign matrix.valid    = ctl_mx.valid;
  assign matrix.part_tag = ctl_mx.tag;
  assign matrix.m00      = m[0];
  assign matrix.m01      = m[1];
  assign matrix.m02      = m[2];
  assign matrix.m10      = m[3];
  assign matrix.m11      = m[4];
  assign matrix.m12      = m[5];
  assign matrix.m20      = m[6];
  assign matrix.m21      = m[7];
  assign matrix.m22      = m[8];

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (matrix.valid && !matrix.ready) |-> !angles.ready)
    else $error("input accepted while output is stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !matrix.valid)
    else $error("result offered right after reset");

  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    matrix.valid |-> (matrix.m00 <= DIAG_MAX && matrix.m00 >= -DIAG_MAX &&
                      matrix.m11 <= DIAG_MAX && matrix.m11 >= -DIAG_MAX &&
                      matrix.m22 <= DIAG_MAX && matrix.m22 >= -DIAG_MAX))
    else $error("diagonal entry exceeds unit magnitude");

endmodule
`default_nettype wire

@@ dv/tb_euler_to_rotation_matrix_unit.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_euler_to_rotation_matrix_unit;
  import e2r_pkg::*;

  // One predicted matrix: the echoed tag and the nine Q2.16 entries.
  typedef struct {
    tag_t   tag;
    entry_t m [9];
  } matrix_t;

  logic clk;
  logic rst;
  int   fail_count;

  // Percent of cycles in which the sender or the receiver stays idle.
  int   send_idle_pct;
  int   recv_idle_pct;
  // Long hold-off on the receiver, counted down in its own process.
  int   recv_hold_cycles;

  matrix_t expected_matrices[$];

  e2r_in_if  angles ();
  e2r_out_if matrix ();

  euler_to_rotation_matrix_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .angles (angles.sink),
    .matrix (matrix.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Rounded Q30 product, half away from zero.
  function automatic longint q30_mul(input longint a, input longint b);
    longint ma;
    longint mb;
    longint r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    r  = (ma * mb + 64'sd536870912) >>> 30;
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // Sine and cosine of half of a binary angle, computed with truncated Taylor series in Q30.
  task automatic half_angle_sincos(input angle_t a, output longint s, output longint c);
    logic [63:0] mag;
    logic [63:0] phi;
    logic [63:0] x2;
    logic [63:0] t;
    longint      sum;
    bit          sub;
    mag = a[ANGLE_BITS-1] ? 64'(65536 - {48'd0, a}) : 64'({48'd0, a});
    phi = (mag * 64'hC90FDAA2 + 64'd32768) >> ANGLE_BITS;
    x2  = (phi * phi + 64'd536870912) >> 30;
    t = phi;
    sum = longint'(phi);
    sub = 1'b1;
    for (int k = 2; k <= 14; k += 2) begin
      t = ((t * x2 + 64'd536870912) >> 30) / 64'(k * (k + 1));
      sum = sub ? sum - longint'(t) : sum + longint'(t);
      sub = !sub;
    end
    s = a[ANGLE_BITS-1] ? -sum : sum;
    t = 64'd1 << 30;
    sum = longint'(t);
    sub = 1'b1;
    for (int k = 1; k <= 15; k += 2) begin
      t = ((t * x2 + 64'd536870912) >> 30) / 64'(k * (k + 1));
      sum = sub ? sum - longint'(t) : sum + longint'(t);
      sub = !sub;
    end
    c = sum;
  endtask

  // Q30 entry rounded to Q2.16 and saturated.
  function automatic entry_t q30_to_entry(input longint v);
    longint m;
    longint lim;
    lim = longint'(1) << (FRAC_BITS + 1);
    m = (((v < 0) ? -v : v) + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (v < 0) begin
      if (m > lim) m = lim;
      return entry_t'(-m);
    end
    if (m > lim - 1) m = lim - 1;
    return entry_t'(m);
  endfunction

  task automatic predict_matrix(input tag_t tag, input angle_t ax, input angle_t ay,
                                input angle_t az, output matrix_t res);
    longint sx, cx, sy, cy, sz, cz;
    longint czcy, szsy, czsy, szcy;
    longint w, x, y, z, ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    half_angle_sincos(ax, sx, cx);
    half_angle_sincos(ay, sy, cy);
    half_angle_sincos(az, sz, cz);
    czcy = q30_mul(cz, cy);
    szsy = q30_mul(sz, sy);
    czsy = q30_mul(cz, sy);
    szcy = q30_mul(sz, cy);
    // ZYX quaternion.
    w = q30_mul(czcy, cx) + q30_mul(szsy, sx);
    x = q30_mul(czcy, sx) - q30_mul(szsy, cx);
    y = q30_mul(czsy, cx) + q30_mul(szcy, sx);
    z = q30_mul(szcy, cx) - q30_mul(czsy, sx);
    ww = q30_mul(w, w); xx = q30_mul(x, x);
    yy = q30_mul(y, y); zz = q30_mul(z, z);
    xy = q30_mul(x, y); xz = q30_mul(x, z); yz = q30_mul(y, z);
    wx = q30_mul(w, x); wy = q30_mul(w, y); wz = q30_mul(w, z);
    res.tag  = tag;
    res.m[0] = q30_to_entry(ww + xx - yy - zz);
    res.m[1] = q30_to_entry(2 * (xy - wz));
    res.m[2] = q30_to_entry(2 * (xz + wy));
    res.m[3] = q30_to_entry(2 * (xy + wz));
    res.m[4] = q30_to_entry(ww - xx + yy - zz);
    res.m[5] = q30_to_entry(2 * (yz - wx));
    res.m[6] = q30_to_entry(2 * (xz - wy));
    res.m[7] = q30_to_entry(2 * (yz + wx));
    res.m[8] = q30_to_entry(ww - xx - yy + zz);
  endtask

  // Offers one angle set, with a random gap in front, and holds it until accepted.
  // The expectation is queued at the accepting edge, ahead of any result.
  // Valid stays high after acceptance so that the next call can follow back to
  // back; idle gaps and the drain drop it.
  task automatic send_angles(input tag_t tag, input angle_t ax, input angle_t ay,
                             input angle_t az);
    matrix_t res;
    predict_matrix(tag, ax, ay, az, res);
    while ($urandom_range(99) < send_idle_pct) begin
      angles.valid <= 1'b0;
      @(posedge clk);
    end
    angles.valid      <= 1'b1;
    angles.part_index <= tag;
    angles.angle_x    <= ax;
    angles.angle_y    <= ay;
    angles.angle_z    <= az;
    do @(posedge clk); while (!angles.ready);
    expected_matrices.push_back(res);
  endtask

  function automatic angle_t random_angle();
    case ($urandom_range(5))
      0: return angle_t'(16'h8000);
      1: return angle_t'(16'h7FFF);
      2: return angle_t'($urandom_range(64) - 32);
      default: return angle_t'($urandom);
    endcase
  endfunction

  task automatic wait_for_drain();
    angles.valid <= 1'b0;
    while (expected_matrices.size() != 0) @(posedge clk);
  endtask

  // Zero angles, each axis alone at the extremes, and mixed corners.
  task automatic test_directed();
    angle_t corners[6];
    corners = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh4000, -16'sh4000, 16'sh0001};
    send_angles(16'h0000, 0, 0, 0);
    send_angles(16'hFFFF, -16'sh8000, -16'sh8000, -16'sh8000);
    send_angles(16'hAAAA, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_angles(16'h5555, -16'sh0001, 16'sh0001, -16'sh0001);
    for (int i = 1; i < 6; i++) begin
      send_angles(16'(16 + i), corners[i], 0, 0);
      send_angles(16'(32 + i), 0, corners[i], 0);
      send_angles(16'(48 + i), 0, 0, corners[i]);
    end
    send_angles(16'h1234, 16'sh4000, -16'sh8000, 16'sh2000);
    send_angles(16'h4321, -16'sh2000, 16'sh4000, 16'sh7FFF);
    wait_for_drain();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_angles(tag_t'($urandom), random_angle(), random_angle(), random_angle());
  endtask

  // No idling on either side, so the pipeline runs at full rate.
  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(120);
    send_idle_pct = 21;
    recv_idle_pct = 21;
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // pipeline fills and the input side must stall.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_hold_cycles = 200;
    test_random(80);
    send_idle_pct = 21;
    wait_for_drain();
  endtask

  // Result side: the only writer of matrix.ready.
  initial begin
    matrix.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        matrix.ready <= 1'b0;
      end else begin
        matrix.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compares each accepted matrix with the oldest expectation.
  initial begin
    matrix_t exp_m;
    entry_t  got [9];
    string   names [9];
    names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
    forever begin
      @(posedge clk);
      if (!rst && matrix.valid && matrix.ready) begin
        got = '{matrix.m00, matrix.m01, matrix.m02, matrix.m10, matrix.m11,
                matrix.m12, matrix.m20, matrix.m21, matrix.m22};
        if (expected_matrices.size() == 0) begin
          $error("unexpected matrix transaction, tag %h", matrix.part_tag);
          fail_count++;
        end else begin
          exp_m = expected_matrices.pop_front();
          if (matrix.part_tag !== exp_m.tag) begin
            $error("part_tag: expected %h, actual %h", exp_m.tag, matrix.part_tag);
            fail_count++;
          end
          for (int i = 0; i < 9; i++)
            if (got[i] !== exp_m.m[i]) begin
              $error("%s: expected %0d, actual %0d", names[i], exp_m.m[i], got[i]);
              fail_count++;
            end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("[euler_to_rotation_matrix_unit] ERROR");
    $finish;
  end

  initial begin
    fail_count       = 0;
    send_idle_pct    = 21;
    recv_idle_pct    = 21;
    recv_hold_cycles = 0;
    rst              = 1'b1;
    angles.valid      <= 1'b0;
    angles.part_index <= '0;
    angles.angle_x    <= '0;
    angles.angle_y    <= '0;
    angles.angle_z    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(150);
    test_full_rate();
    test_backpressure();
    // The sender pauses here until every result has come back.
    test_random(150);

    wait_for_drain();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_matrices.size() == 0) begin
      $display("[euler_to_rotation_matrix_unit] OK");
    end else begin
      $display("[euler_to_rotation_matrix_unit] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
